FILE: hdl/ormq_pkg.sv
// Shared types and constants for the overwriting message ring queue.
package ormq_pkg;

  // Fixed field widths of the request and result channels
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int CAP_W  = 12;
  localparam int STAT_W = 2;
  localparam int WORD_W = 64;
  localparam int VB_W   = 4;
  localparam int LINE_W = 8;
  localparam int WORD_BYTES = 8;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_SMALL = 2'd2;

  // Controller states
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CM_RD   = 8'b0000_0010,
    S_CM_WR   = 8'b0000_0100,
    S_CM_FIN  = 8'b0000_1000,
    S_RD_LEN  = 8'b0001_0000,
    S_RD_WORD = 8'b0010_0000,
    S_RD_OUT  = 8'b0100_0000,
    S_RD_STAT = 8'b1000_0000
  } ormq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              accept;
    logic              push;
    logic              idx_inc;
    logic              slot_wr;
    logic              commit_fin;
    logic              latch_len;
    logic              emit_stat;
    logic              emit_word;
    logic              free_slot;
    logic [STAT_W-1:0] stat_code;
  } ormq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic stage_empty;
    logic stg_last;
    logic len_zero;
    logic cap_short;
    logic rd_last;
    logic out_free;
  } ormq_status_t;

endpackage

FILE: hdl/ormq_ram.sv
// Generic simple dual-port RAM with registered read.
module ormq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/ormq_ctrl.sv
// Controller state machine for the message ring queue.
module ormq_ctrl import ormq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [OP_W-1:0]   opcode,
  input  ormq_status_t      stat,
  output logic              in_stall,
  output ormq_cmd_t         cmd
);

  ormq_state_t       state, state_next;
  logic [STAT_W-1:0] pend_code, pend_code_next;
  logic              pend_free, pend_free_next;

  // Requests are taken only between operations
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_code <= ST_OK;
      pend_free <= 1'b0;
    end else begin
      state     <= state_next;
      pend_code <= pend_code_next;
      pend_free <= pend_free_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next     = state;
    pend_code_next = pend_code;
    pend_free_next = pend_free;
    cmd            = '0;
    cmd.stat_code  = pend_code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (opcode)
            OP_PUSH: begin
              cmd.push = 1'b1;
            end
            OP_COMMIT: begin
              state_next = stat.stage_empty ? S_CM_FIN : S_CM_RD;
            end
            OP_READ: begin
              if (stat.count_zero) begin
                pend_code_next = ST_EMPTY;
                pend_free_next = 1'b0;
                state_next     = S_RD_STAT;
              end else begin
                state_next = S_RD_LEN;
              end
            end
            default: begin
              // unused opcode: dropped
            end
          endcase
        end
      end
      S_CM_RD: begin
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        cmd.slot_wr = 1'b1;
        if (stat.stg_last) begin
          state_next = S_CM_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CM_RD;
        end
      end
      S_CM_FIN: begin
        cmd.commit_fin = 1'b1;
        state_next     = S_IDLE;
      end
      S_RD_LEN: begin
        cmd.latch_len = 1'b1;
        if (stat.cap_short) begin
          pend_code_next = ST_TOO_SMALL;
          pend_free_next = 1'b0;
          state_next     = S_RD_STAT;
        end else if (stat.len_zero) begin
          pend_code_next = ST_OK;
          pend_free_next = 1'b1;
          state_next     = S_RD_STAT;
        end else begin
          state_next = S_RD_WORD;
        end
      end
      S_RD_WORD: begin
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.emit_word = 1'b1;
          if (stat.rd_last) begin
            cmd.free_slot = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD_WORD;
          end
        end
      end
      S_RD_STAT: begin
        if (stat.out_free) begin
          cmd.emit_stat = 1'b1;
          cmd.free_slot = pend_free;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ormq_datapath.sv
// Datapath: staging line, slot memories, ring pointers and result register.
module ormq_datapath import ormq_pkg::*; #(
  parameter int RING_DEPTH  = 64,
  parameter int ENTRY_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  ormq_cmd_t          cmd,
  output ormq_status_t       stat,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [CAP_W-1:0]   read_capacity,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [STAT_W-1:0]  status,
  output logic [WORD_W-1:0]  data_word,
  output logic [VB_W-1:0]    valid_bytes,
  output logic [LINE_W-1:0]  line_length,
  output logic               last
);

  localparam int WORDS    = (ENTRY_BYTES + 7) / 8;
  localparam int WB       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SB       = $clog2(RING_DEPTH);
  localparam int CW       = $clog2(RING_DEPTH + 1);
  localparam int LEN_W    = $clog2(ENTRY_BYTES);
  localparam int MAX_LINE = ENTRY_BYTES - 1;

  logic [SB-1:0]     head, tail;
  logic [CW-1:0]     count;
  logic [LEN_W-1:0]  staged_len;
  logic [WORD_W-1:0] asm_word, asm_word_next;
  logic [WB-1:0]     idx;
  logic [CAP_W-1:0]  cap_reg;
  logic [LEN_W-1:0]  rd_len;

  logic [2:0]        offset;
  logic              push_take;
  logic              stg_wr_en;
  logic [WB-1:0]     stg_wr_addr;
  logic [WORD_W-1:0] stg_rd_data;
  logic [WB-1:0]     stg_last_idx, rd_last_idx;
  logic [WORD_W-1:0] text_wr_data, text_rd_data;
  logic [LEN_W-1:0]  len_rd;
  logic [SB-1:0]     head_adv, tail_adv;
  logic              ring_full;

  // Byte assembly: a word starts fresh at its first byte
  assign offset        = staged_len[2:0];
  assign asm_word_next = (offset == 3'd0) ? WORD_W'(data_byte)
                       : (asm_word | (WORD_W'(data_byte) << {offset, 3'b000}));
  assign push_take     = cmd.push && (staged_len < LEN_W'(MAX_LINE));
  assign stg_wr_en     = push_take && (offset == 3'd7);
  assign stg_wr_addr   = WB'(staged_len >> 3);

  // Last word indexes for commit copy and read streaming
  assign stg_last_idx = WB'((staged_len - LEN_W'(1)) >> 3);
  assign rd_last_idx  = WB'((rd_len - LEN_W'(1)) >> 3);

  // A trailing partial word still sits in the assembly register
  assign text_wr_data = (stat.stg_last && (staged_len[2:0] != 3'd0)) ? asm_word
                                                                      : stg_rd_data;

  // Ring pointer wrap
  assign head_adv  = (head == SB'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_adv  = (tail == SB'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign ring_full = (count == CW'(RING_DEPTH));

  // Status toward the controller
  assign stat.count_zero  = (count == '0);
  assign stat.stage_empty = (staged_len == '0);
  assign stat.stg_last    = (idx == stg_last_idx);
  assign stat.len_zero    = (len_rd == '0);
  assign stat.cap_short   = (cap_reg < CAP_W'(len_rd));
  assign stat.rd_last     = (idx == rd_last_idx);
  assign stat.out_free    = !out_valid || !out_stall;

  // Staging line: completed words only
  ormq_ram #(.WIDTH(WORD_W), .DEPTH(1 << WB)) u_stage_ram (
    .clk     (clk),
    .wr_en   (stg_wr_en),
    .wr_addr (stg_wr_addr),
    .wr_data (asm_word_next),
    .rd_addr (idx),
    .rd_data (stg_rd_data)
  );

  // Slot text, addressed by slot and word
  ormq_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH << WB)) u_text_ram (
    .clk     (clk),
    .wr_en   (cmd.slot_wr),
    .wr_addr ({tail, idx}),
    .wr_data (text_wr_data),
    .rd_addr ({head, idx}),
    .rd_data (text_rd_data)
  );

  // Slot lengths
  ormq_ram #(.WIDTH(LEN_W), .DEPTH(RING_DEPTH)) u_len_ram (
    .clk     (clk),
    .wr_en   (cmd.commit_fin),
    .wr_addr (tail),
    .wr_data (staged_len),
    .rd_addr (head),
    .rd_data (len_rd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      staged_len <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (push_take) begin
        staged_len <= staged_len + 1'b1;
      end
      if (cmd.commit_fin) begin
        staged_len <= '0;
        tail       <= tail_adv;
        if (ring_full) begin
          head <= head_adv;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (cmd.free_slot) begin
        head  <= head_adv;
        count <= count - 1'b1;
      end
      if (cmd.emit_stat || cmd.emit_word) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cap_reg <= read_capacity;
    end
    if (push_take) begin
      asm_word <= asm_word_next;
    end
    if (cmd.latch_len) begin
      rd_len <= len_rd;
    end
    if (cmd.emit_stat) begin
      status      <= cmd.stat_code;
      data_word   <= '0;
      valid_bytes <= '0;
      line_length <= '0;
      last        <= 1'b1;
    end else if (cmd.emit_word) begin
      status      <= ST_OK;
      data_word   <= text_rd_data;
      valid_bytes <= (stat.rd_last && (rd_len[2:0] != 3'd0)) ? VB_W'(rd_len[2:0])
                                                              : VB_W'(WORD_BYTES);
      line_length <= LINE_W'(rd_len);
      last        <= stat.rd_last;
    end
  end

endmodule

FILE: hdl/overwriting_message_ring_queue.sv
// Top level of the overwriting message ring queue.
// Usage:
//   Requests arrive on in_valid/in_stall with opcode, data_byte, read_capacity.
//   Push appends one byte to the staging line; pushes stream one per cycle.
//   Bytes beyond ENTRY_BYTES-1 are dropped.
//   Commit copies the staged line into the tail slot: a staging RAM read
//   then a slot RAM write per 8-byte word, then a finishing step.
//   A full ring overwrites its oldest line.
//   Read returns the oldest line on out_valid/out_stall as 8-byte words,
//   last marking the final one: the request, a length lookup, then a slot
//   RAM read per word. An empty read skips the length lookup; a too-small
//   or zero-length read ends after it; each gives a single status result.
//   Push and commit produce no result.
//   Reset empties the ring and the staging line at once; no clearing pass.
//   When the receiver stalls, the result register holds its word and the
//   read sequence waits; in_stall stays high until the request completes.
module overwriting_message_ring_queue import ormq_pkg::*; #(
  parameter int RING_DEPTH  = 64,
  parameter int ENTRY_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    opcode,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [CAP_W-1:0]   read_capacity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [WORD_W-1:0]  data_word,
  output logic [VB_W-1:0]    valid_bytes,
  output logic [LINE_W-1:0]  line_length,
  output logic               last
);

  ormq_cmd_t    cmd;
  ormq_status_t stat;

  ormq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ormq_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .data_byte     (data_byte),
    .read_capacity (read_capacity),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .data_word     (data_word),
    .valid_bytes   (valid_bytes),
    .line_length   (line_length),
    .last          (last)
  );

endmodule

FILE: hdl/ormq_checker.sv
// Port-level checks for the message ring queue, bound to the top level.
module ormq_checker import ormq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [WORD_W-1:0] data_word,
  input logic [VB_W-1:0]   valid_bytes,
  input logic [LINE_W-1:0] line_length,
  input logic              last
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_word) && $stable(last))
    else $error("stalled result changed");

  // Mid-line the block is still streaming and takes no new request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("request taken while a line is still streaming");

  // Error results are single, empty results
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |->
      last && (data_word == '0) && (valid_bytes == '0) && (line_length == '0))
    else $error("error result carries data");

  // Non-final words are full and successful
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (status == ST_OK) && (valid_bytes == VB_W'(WORD_BYTES)))
    else $error("partial word before end of line");

endmodule

bind overwriting_message_ring_queue ormq_checker u_checker (.*);

FILE: sim/tb.sv
// Testbench for the overwriting message ring queue: directed table, ring flood, overlong line, then random traffic.
module tb;
  import ormq_pkg::*;

  localparam int RING_SLOTS = 64;
  localparam int SLOT_BYTES = 256;
  localparam int LINE_MAX   = SLOT_BYTES - 1;
  localparam int ITEM_GOAL  = 470;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One word of a read result
  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   nbytes;
    logic [LINE_W-1:0] len;
    logic              last;
  } read_word_t;

  // Directed request; typed rows carry a single status-only result
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] db;
    logic [CAP_W-1:0]  cap;
    logic              typed;
    logic [STAT_W-1:0] st;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   opcode = OP_PUSH;
  logic [BYTE_W-1:0] data_byte = '0;
  logic [CAP_W-1:0]  read_capacity = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] data_word;
  logic [VB_W-1:0]   valid_bytes;
  logic [LINE_W-1:0] line_length;
  logic              last;

  // Typed expectation travels with the request it belongs to
  logic              row_typed = 1'b0;
  logic [STAT_W-1:0] row_status = ST_OK;
  logic              gaps_on = 1'b1;

  int mismatches = 0;
  int sent = 0;

  // Shadow of the ring: staging line, slots, pointers
  logic [7:0] stage_bytes [LINE_MAX];
  int         stage_len = 0;
  logic [7:0] slot_bytes [RING_SLOTS][LINE_MAX];
  int         slot_len [RING_SLOTS];
  int         head_slot = 0;
  int         tail_slot = 0;
  int         used_slots = 0;
  read_word_t words_due [$];
  read_word_t step_words [$];

  dir_row_t dir_table [25] = '{
    '{OP_READ,   8'h00, 12'h000, 1'b1, ST_EMPTY},
    '{OP_UNUSED, 8'hFF, 12'hFFF, 1'b0, ST_OK},
    '{OP_COMMIT, 8'h00, 12'h000, 1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'h000, 1'b1, ST_OK},
    '{OP_PUSH,   8'h00, 12'hFFF, 1'b0, ST_OK},
    '{OP_PUSH,   8'hFF, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'h5A, 12'hAAA, 1'b0, ST_OK},
    '{OP_PUSH,   8'hA5, 12'h555, 1'b0, ST_OK},
    '{OP_PUSH,   8'h01, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'h80, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'h7F, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'hFE, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'h33, 12'h000, 1'b0, ST_OK},
    '{OP_COMMIT, 8'h00, 12'h000, 1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'd8,   1'b1, ST_TOO_SMALL},
    '{OP_READ,   8'h00, 12'd9,   1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'hFFF, 1'b1, ST_EMPTY},
    '{OP_PUSH,   8'h11, 12'h000, 1'b0, ST_OK},
    '{OP_COMMIT, 8'h00, 12'h000, 1'b0, ST_OK},
    '{OP_PUSH,   8'h22, 12'h000, 1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'hFFF, 1'b0, ST_OK},
    '{OP_COMMIT, 8'h00, 12'h000, 1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'd1,   1'b0, ST_OK},
    '{OP_UNUSED, 8'h00, 12'h000, 1'b0, ST_OK},
    '{OP_READ,   8'h00, 12'h000, 1'b1, ST_EMPTY}
  };

  overwriting_message_ring_queue #(
    .RING_DEPTH (RING_SLOTS),
    .ENTRY_BYTES(SLOT_BYTES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .read_capacity(read_capacity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_word    (data_word),
    .valid_bytes  (valid_bytes),
    .line_length  (line_length),
    .last         (last)
  );

  always #4 clk = ~clk;

  // Update the shadow ring for one request; read words land in step_words
  task automatic ring_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] db,
                              input logic [CAP_W-1:0] cap);
    int nw;
    int len;
    int rem;
    read_word_t r;
    step_words.delete();
    case (op)
      OP_PUSH: begin
        // bytes past the line limit are dropped
        if (stage_len < LINE_MAX) begin
          stage_bytes[stage_len] = db;
          stage_len++;
        end
      end
      OP_COMMIT: begin
        for (int i = 0; i < stage_len; i++) slot_bytes[tail_slot][i] = stage_bytes[i];
        slot_len[tail_slot] = stage_len;
        // full ring: oldest line is overwritten
        if (used_slots == RING_SLOTS) head_slot = (head_slot + 1) % RING_SLOTS;
        else used_slots++;
        tail_slot = (tail_slot + 1) % RING_SLOTS;
        stage_len = 0;
      end
      OP_READ: begin
        r = '0;
        r.last = 1'b1;
        if (used_slots == 0) begin
          r.st = ST_EMPTY;
          step_words.push_back(r);
        end else if (int'(cap) < slot_len[head_slot]) begin
          r.st = ST_TOO_SMALL;
          step_words.push_back(r);
        end else begin
          len = slot_len[head_slot];
          nw = (len + 7) / 8;
          if (nw == 0) begin
            r.st = ST_OK;
            step_words.push_back(r);
          end
          for (int w = 0; w < nw; w++) begin
            rem = len - w * 8;
            r.st = ST_OK;
            r.word = '0;
            r.nbytes = VB_W'((rem > WORD_BYTES) ? WORD_BYTES : rem);
            r.len = LINE_W'(len);
            r.last = (w == nw - 1);
            for (int b = 0; b < int'(r.nbytes); b++)
              r.word[b*8 +: 8] = slot_bytes[head_slot][w*8 + b];
            step_words.push_back(r);
          end
          head_slot = (head_slot + 1) % RING_SLOTS;
          used_slots--;
        end
      end
      default: ;
    endcase
  endtask

  // Predict on accepted requests, check accepted results
  always @(posedge clk) begin : watch
    read_word_t got;
    read_word_t want;
    read_word_t typed_word;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        ring_request(opcode, data_byte, read_capacity);
        if (row_typed) begin
          typed_word = '0;
          typed_word.st = row_status;
          typed_word.last = 1'b1;
          words_due.push_back(typed_word);
        end else begin
          foreach (step_words[k]) words_due.push_back(step_words[k]);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{status, data_word, valid_bytes, line_length, last};
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: st=%0d word=%h vb=%0d len=%0d last=%0d",
                     got.st, got.word, got.nbytes, got.len, got.last);
        end else begin
          want = words_due.pop_front();
          if (got.st !== want.st || got.word !== want.word || got.nbytes !== want.nbytes ||
              got.len !== want.len || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d word=%h vb=%0d len=%0d last=%0d",
                       want.st, want.word, want.nbytes, want.len, want.last,
                       " / got st=%0d word=%h vb=%0d len=%0d last=%0d",
                       got.st, got.word, got.nbytes, got.len, got.last);
          end
        end
      end
    end
  end

  // Receiver stalls at random while gaps are enabled
  always @(posedge clk) out_stall <= gaps_on && ($urandom_range(0, 99) < 12);

  // Present one request and hold it until accepted
  task automatic send(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] db,
                      input logic [CAP_W-1:0] cap, input logic typed,
                      input logic [STAT_W-1:0] st);
    if (gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    data_byte     <= db;
    read_capacity <= cap;
    row_typed     <= typed;
    row_status    <= st;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic push_byte();
    send(OP_PUSH, BYTE_W'($urandom), CAP_W'($urandom), 1'b0, ST_OK);
  endtask

  // Capacity spread: roomy, any value, tiny, and around the line limit
  function automatic logic [CAP_W-1:0] pick_capacity();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return '1;
    if (p < 65) return CAP_W'($urandom);
    if (p < 88) return CAP_W'($urandom_range(0, 24));
    return CAP_W'($urandom_range(LINE_MAX - 8, LINE_MAX + 8));
  endfunction

  initial begin : stim
    int pick;
    int nlen;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_table[i])
      send(dir_table[i].op, dir_table[i].db, dir_table[i].cap, dir_table[i].typed,
           dir_table[i].st);

    // flood past the ring size with no gaps, then drain it
    gaps_on <= 1'b0;
    for (int n = 0; n < RING_SLOTS + 6; n++) begin
      repeat ($urandom_range(0, 1)) push_byte();
      send(OP_COMMIT, '0, '0, 1'b0, ST_OK);
    end
    for (int n = 0; n < RING_SLOTS + 2; n++) send(OP_READ, '0, '1, 1'b0, ST_OK);
    gaps_on <= 1'b1;

    // overlong line is truncated; read it one byte short, then exactly
    repeat (LINE_MAX + 4) push_byte();
    send(OP_COMMIT, '0, '0, 1'b0, ST_OK);
    send(OP_READ, '0, CAP_W'(LINE_MAX - 1), 1'b0, ST_OK);
    send(OP_READ, '0, CAP_W'(LINE_MAX), 1'b0, ST_OK);

    // mixed traffic: whole lines, reads, half-built lines, unused opcode
    while (sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
        repeat (nlen) push_byte();
        send(OP_COMMIT, BYTE_W'($urandom), CAP_W'($urandom), 1'b0, ST_OK);
      end else if (pick < 85) begin
        send(OP_READ, BYTE_W'($urandom), pick_capacity(), 1'b0, ST_OK);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 10)) push_byte();
        send(OP_READ, BYTE_W'($urandom), pick_capacity(), 1'b0, ST_OK);
      end else begin
        send(OP_UNUSED, BYTE_W'($urandom), CAP_W'($urandom), 1'b0, ST_OK);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let a trailing commit finish
    while (words_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
